FILE: sv/bdepq_pkg.sv
// Shared constants, types and codes of the bounded double-ended priority queue.
package bdepq_pkg;

	localparam int DEPTH      = 64;
	localparam int TAG_BITS   = 32;
	localparam int PRIO_W     = 64;
	localparam int PORT_TAG_W = 32;
	localparam int REQ_W      = 2;
	// one spare slot: an insert into a full queue lands there before the trim
	localparam int SLOTS      = DEPTH + 1;
	localparam int IDX_W      = $clog2(SLOTS);
	localparam int CNT_W      = $clog2(SLOTS + 1);
	localparam int CAP_W      = 7;
	localparam int TOTAL_W    = 7;
	localparam int CMP_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;
	localparam int S_TDATA_W  = 96;
	localparam int M_TDATA_W  = 104;
	localparam int CAP_RESET  = 64;

	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT     = 2'd0,
		REQ_PULL_BEST  = 2'd1,
		REQ_PULL_WORST = 2'd2
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PREFER_LOWEST  = 1'b0,
		CFG_CAPACITY_LIMIT = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_WRITE,
		CELL_ROTATE,
		CELL_REMOVE
	} cell_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_REMOVE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		cell_op_t         op;
		logic [IDX_W-1:0] pos;
	} cell_cmd_t;

	typedef struct packed {
		logic [PRIO_W-1:0]   prio;
		logic [TAG_BITS-1:0] tag;
	} entry_t;

endpackage

FILE: sv/bdepq_cell.sv
// One cell of the queue chain: holds an entry; loads input, neighbour or head.
module bdepq_cell
	import bdepq_pkg::*;
(
	input  logic             clk,
	input  cell_cmd_t        cmd,
	input  logic [IDX_W-1:0] cell_idx,
	input  entry_t           new_entry,
	input  entry_t           next_entry,
	input  entry_t           head_entry,
	output entry_t           entry
);

	entry_t entry_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_WRITE: begin
				if (cell_idx == cmd.pos) entry_q <= new_entry;
			end
			CELL_ROTATE: begin
				// last live cell wraps round to the head
				if (cell_idx == cmd.pos) entry_q <= head_entry;
				else if (cell_idx < cmd.pos) entry_q <= next_entry;
			end
			CELL_REMOVE: begin
				if (cell_idx >= cmd.pos) entry_q <= next_entry;
			end
			default: begin
			end
		endcase
	end

	assign entry = entry_q;

endmodule

FILE: sv/bdepq_ctrl.sv
// Sequencer of the queue: config registers, head compare, count and result register.
module bdepq_ctrl
	import bdepq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [REQ_W-1:0]      req,
	input  entry_t                head_entry,
	output cell_cmd_t             cmd,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic                  out_status,
	output logic                  out_drop,
	output entry_t                out_entry,
	output logic [TOTAL_W-1:0]    out_total
);

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   cnt_q;
	logic               prefer_lowest_q;
	logic [CAP_W-1:0]   cap_q;
	logic               ins_q, worst_q;
	logic [IDX_W-1:0]   k_q, sel_q;
	entry_t             cand_q, res_entry_q;
	logic               res_status_q, res_drop_q;
	logic               m_valid_q;

	logic [CMP_W-1:0]   limit, cnt_ext, cnt_dec_ext, cap_ext;
	logic [CNT_W-1:0]   cnt_dec;
	logic [IDX_W-1:0]   last_idx;
	logic               head_better, cand_better, take, accept, out_load;
	req_t               req_e;

	assign req_e       = req_t'(req);
	assign accept      = s_tvalid && s_tready;
	assign cap_ext     = CMP_W'(cap_q);
	assign limit       = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
	assign cnt_dec     = cnt_q - CNT_W'(1);
	assign cnt_ext     = CMP_W'(cnt_q);
	assign cnt_dec_ext = CMP_W'(cnt_dec);
	assign last_idx    = IDX_W'(cnt_dec);

	assign head_better = prefer_lowest_q ? (head_entry.prio < cand_q.prio)
	                                     : (head_entry.prio > cand_q.prio);
	assign cand_better = prefer_lowest_q ? (cand_q.prio < head_entry.prio)
	                                     : (cand_q.prio > head_entry.prio);
	// strict compare keeps the oldest of equal priorities
	assign take        = (k_q == '0) || (worst_q ? cand_better : head_better);
	assign out_load    = (state_q == ST_FINISH) && (!m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd.op   = CELL_HOLD;
		cmd.pos  = '0;
		s_tready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					case (req_e)
						REQ_INSERT: begin
							cmd.op  = CELL_WRITE;
							cmd.pos = IDX_W'(cnt_q);
							state_d = ST_CHECK;
						end
						REQ_PULL_BEST, REQ_PULL_WORST: begin
							state_d = (cnt_q == '0) ? ST_FINISH : ST_SCAN;
						end
						default: state_d = ST_FINISH;
					endcase
				end
			end
			ST_CHECK: begin
				state_d = (cnt_ext > limit) ? ST_SCAN : ST_FINISH;
			end
			ST_SCAN: begin
				cmd.op  = CELL_ROTATE;
				cmd.pos = last_idx;
				if (k_q == last_idx) state_d = ST_REMOVE;
			end
			ST_REMOVE: begin
				cmd.op  = CELL_REMOVE;
				cmd.pos = sel_q;
				state_d = (ins_q && (cnt_dec_ext > limit)) ? ST_SCAN : ST_FINISH;
			end
			ST_FINISH: begin
				if (!m_valid_q || m_tready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q           <= '0;
			prefer_lowest_q <= 1'b0;
			cap_q           <= CAP_W'(CAP_RESET);
			m_valid_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_PREFER_LOWEST:  prefer_lowest_q <= cfg_data[0];
					CFG_CAPACITY_LIMIT: cap_q <= cfg_data[CAP_W-1:0];
					default: begin
					end
				endcase
			end
			if (accept && (req_e == REQ_INSERT)) cnt_q <= cnt_q + CNT_W'(1);
			else if (state_q == ST_REMOVE) cnt_q <= cnt_dec;
			if (out_load) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			ins_q        <= (req_e == REQ_INSERT);
			worst_q      <= (req_e != REQ_PULL_BEST);
			res_status_q <= ((req_e == REQ_PULL_BEST) || (req_e == REQ_PULL_WORST))
			                && (cnt_q == '0);
			res_entry_q  <= '0;
			res_drop_q   <= 1'b0;
			k_q          <= '0;
		end
		if (state_q == ST_SCAN) begin
			k_q <= k_q + IDX_W'(1);
			if (take) begin
				cand_q <= head_entry;
				sel_q  <= k_q;
			end
		end
		if (state_q == ST_REMOVE) begin
			k_q <= '0;
			if (ins_q) res_drop_q <= 1'b1;
			else res_entry_q <= cand_q;
		end
		if (out_load) begin
			out_status <= res_status_q;
			out_drop   <= res_drop_q;
			out_entry  <= res_entry_q;
			out_total  <= cnt_ext[TOTAL_W-1:0];
		end
	end

	assign m_tvalid = m_valid_q;

`ifndef SYNTH
	a_remove_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_REMOVE |-> cnt_q != '0)
		else $error("remove with empty queue");
	a_sel_behind_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) && (k_q != '0) |-> sel_q < k_q)
		else $error("selected slot ahead of scan position");
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q != ST_IDLE)
		else $error("accepted beat not taken into work");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> cnt_ext <= CMP_W'(DEPTH))
		else $error("entry count above depth while idle");
`endif

endmodule

FILE: sv/bounded_double_ended_priority_queue.sv
// Insert: accept, CHECK, then FINISH loads the result; each trimmed entry adds a SCAN
// pass over the live entries and a REMOVE. Pull: SCAN walks the chain one cell per cycle
// (head compare), then REMOVE and FINISH; an empty pull goes straight to FINISH. One
// request at a time: the next beat is taken once the result sits in the output register.
// Reset (arst_n low, asynchronous): queue empty, prefer largest, capacity limit 64.
// Slot contents have no reset; only the first count slots are ever read.
module bounded_double_ended_priority_queue
	import bdepq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// register write port: 0 prefer_lowest, 1 capacity_limit
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// request stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,  // prio_in[63:0], tag_in[95:64]
	input  logic [REQ_W-1:0]      s_tuser,  // req_type[1:0]
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,  // prio_out[63:0], tag_out[95:64],
	                                        // entry_total[102:96], zero[103]
	output logic [1:0]            m_tuser   // status[0], dropped[1]
);

	// Entries sit in arrival order, slot 0 oldest. A search rotates the live part of
	// the chain so that every entry passes the head once while the sequencer keeps
	// the running best/worst candidate; a removal then closes the gap by shifting later entries.
	entry_t            cells [SLOTS];
	entry_t            new_entry, out_entry;
	cell_cmd_t         cmd;
	logic              out_status, out_drop;
	logic [TOTAL_W-1:0] out_total;

	assign new_entry.prio = s_tdata[PRIO_W-1:0];
	assign new_entry.tag  = TAG_BITS'(s_tdata[PRIO_W+PORT_TAG_W-1:PRIO_W]);

	for (genvar i = 0; i < SLOTS; i++) begin : g_chain
		entry_t next_entry;
		if (i == SLOTS - 1) begin : g_end
			assign next_entry = cells[i];
		end else begin : g_mid
			assign next_entry = cells[i+1];
		end
		bdepq_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.cell_idx   (IDX_W'(i)),
			.new_entry  (new_entry),
			.next_entry (next_entry),
			.head_entry (cells[0]),
			.entry      (cells[i])
		);
	end

	bdepq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.req        (s_tuser),
		.head_entry (cells[0]),
		.cmd        (cmd),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.out_status (out_status),
		.out_drop   (out_drop),
		.out_entry  (out_entry),
		.out_total  (out_total)
	);

	// result beat packing; pad bit fills tdata to whole bytes
	assign m_tdata = {1'b0, out_total, PORT_TAG_W'(out_entry.tag), out_entry.prio};
	assign m_tuser = {out_drop, out_status};

endmodule
